[rtl/sacl_pkg.sv]
`timescale 1ns / 1ps
package sacl_pkg;

  // fixed field widths
  localparam int ADDR_W      = 31;
  localparam int TAG_W       = 28;            // address bits above the smallest block offset
  localparam int BB_W        = 3;             // block_bytes_log2
  localparam int SC_W        = 4;             // set_count_log2
  localparam int WL_W        = 2;             // ways_log2
  localparam int WAY_OUT_W   = 3;
  localparam int CNT_W       = 32;
  localparam int BYTE_W      = 40;
  localparam int BLK_LOG_MIN = 3;
  localparam int BLK_LOG_MAX = 6;
  localparam int WAY_LOG_CAP = 3;             // log2 of the largest way count the register can name

  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 152;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  localparam int DEF_MAX_BLOCKS = 8192;
  localparam int DEF_MAX_WAYS   = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS  = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } sacl_state_t;

  typedef struct packed {
    logic             vld;
    logic [TAG_W-1:0] tag;
  } tag_ent_t;

  typedef struct packed {
    logic            fire;
    logic            hit;
    logic            is_write;
    logic [BB_W-1:0] blk_log;
  } ctr_evt_t;

  typedef struct packed {
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  accesses;
    logic [BYTE_W-1:0] fill;
    logic [BYTE_W-1:0] wb;
  } ctr_val_t;

  function automatic int flog2(input int v);
    int r;
    r = 0;
    for (int i = 0; i < 30; i++) begin
      if ((1 << (i + 1)) <= v) r = i + 1;
    end
    return r;
  endfunction

  function automatic int min_int(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

endpackage

[rtl/sacl_dir_mem.sv]
`timescale 1ns / 1ps
module sacl_dir_mem #(
  parameter int ROWS  = 1024,
  parameter int ROW_W = 10,
  parameter int LANES = 8,
  parameter int LW    = 3
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [ROW_W-1:0]                  rd_addr,
  input  logic                              wr_en,
  input  logic [ROW_W-1:0]                  wr_addr,
  input  sacl_pkg::tag_ent_t [LANES-1:0]    wr_tag,
  input  logic [LANES-1:0][LW-1:0]          wr_lru,
  output sacl_pkg::tag_ent_t [LANES-1:0]    rd_tag,
  output logic [LANES-1:0][LW-1:0]          rd_lru
);
  import sacl_pkg::*;

  // one row holds every lane of an aligned group of ways
  tag_ent_t [LANES-1:0]     tag_mem [ROWS];
  logic [LANES-1:0][LW-1:0] lru_mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_tag;
      lru_mem[wr_addr] <= wr_lru;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tag <= tag_mem[rd_addr];
      rd_lru <= lru_mem[rd_addr];
    end
  end

endmodule

[rtl/sacl_set_upd.sv]
`timescale 1ns / 1ps
module sacl_set_upd #(
  parameter int LANES = 8,
  parameter int LW    = 3
) (
  input  sacl_pkg::tag_ent_t [LANES-1:0]  tag_row,
  input  logic [LANES-1:0][LW-1:0]        lru_row,
  input  logic [LW-1:0]                   off,       // first lane of the set, aligned
  input  logic [LW-1:0]                   way_mask,  // ways - 1
  input  logic [sacl_pkg::TAG_W-1:0]      tag,
  output logic                            hit,
  output logic [LW-1:0]                   way,
  output sacl_pkg::tag_ent_t [LANES-1:0]  tag_row_nx,
  output logic [LANES-1:0][LW-1:0]        lru_row_nx
);
  import sacl_pkg::*;

  logic [LANES-1:0][LW-1:0] lru_sh;
  logic [LW-1:0]            pos;

  assign lru_sh = lru_row >> LW;

  always_comb begin
    logic [LW-1:0] lane;
    logic [LW-1:0] rel;
    logic          in_set;
    hit        = 1'b0;
    way        = '0;
    pos        = '0;
    lru_row_nx = lru_row;
    tag_row_nx = tag_row;

    // tag match, last matching way wins
    for (int j = 0; j < LANES; j++) begin
      lane   = LW'(j);
      rel    = lane & way_mask;
      in_set = (lane & ~way_mask) == off;
      if (in_set && tag_row[j].vld && (tag_row[j].tag == tag)) begin
        hit = 1'b1;
        way = rel;
      end
    end

    // miss: victim is the least recent position
    if (!hit) way = lru_row[off] & way_mask;

    for (int j = 0; j < LANES; j++) begin
      lane   = LW'(j);
      rel    = lane & way_mask;
      in_set = (lane & ~way_mask) == off;
      if (in_set && ((lru_row[j] & way_mask) == way)) pos = rel;
    end

    // close the gap at pos, way goes to most recent
    for (int j = 0; j < LANES; j++) begin
      lane   = LW'(j);
      rel    = lane & way_mask;
      in_set = (lane & ~way_mask) == off;
      if (in_set) begin
        if (rel == way_mask) begin
          lru_row_nx[j] = way;
        end else if (rel >= pos) begin
          lru_row_nx[j] = lru_sh[j];
        end
      end
    end

    if (!hit) begin
      tag_row_nx[off | way].vld = 1'b1;
      tag_row_nx[off | way].tag = tag;
    end
  end

endmodule

[rtl/sacl_counters.sv]
`timescale 1ns / 1ps
module sacl_counters (
  input  logic               clk,
  input  logic               rst_n,
  input  sacl_pkg::ctr_evt_t evt,
  output sacl_pkg::ctr_val_t cnt_nxt
);
  import sacl_pkg::*;

  ctr_val_t cnt_r;

  logic [CNT_W:0]    hit_sum;
  logic [CNT_W:0]    acc_sum;
  logic [BYTE_W:0]   fill_sum;
  logic [BYTE_W:0]   wb_sum;
  logic [BYTE_W-1:0] blk_bytes;

  assign blk_bytes = BYTE_W'(1) << evt.blk_log;
  assign hit_sum   = {1'b0, cnt_r.hits} + (CNT_W + 1)'(1);
  assign acc_sum   = {1'b0, cnt_r.accesses} + (CNT_W + 1)'(1);
  assign fill_sum  = {1'b0, cnt_r.fill} + {1'b0, blk_bytes};
  assign wb_sum    = {1'b0, cnt_r.wb} + {1'b0, blk_bytes};

  // saturate on carry out
  always_comb begin
    cnt_nxt = cnt_r;
    if (evt.fire) begin
      cnt_nxt.accesses = acc_sum[CNT_W] ? '1 : acc_sum[CNT_W-1:0];
      if (evt.hit) begin
        cnt_nxt.hits = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
      end else if (evt.is_write) begin
        cnt_nxt.wb = wb_sum[BYTE_W] ? '1 : wb_sum[BYTE_W-1:0];
      end else begin
        cnt_nxt.fill = fill_sum[BYTE_W] ? '1 : fill_sum[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/set_assoc_cache_lru_model_core.sv]
`timescale 1ns / 1ps
// channel  | dir | beat                 | tdata / data, low bit first
// ---------+-----+----------------------+---------------------------------------------
// in_      | in  | one access           | address[30:0]; tuser = kind (0 read, 1 write)
// out_     | out | one result           | way_used, hit_total, access_total,
//          |     |                      | fill_bytes, writeback_bytes; tuser = hit
// cfg_     | in  | one register write   | cfg_index 0 block, 1 sets, 2 ways
//
// Each access reads the row from the directory memories, then does the
// compare, LRU update and write-back of the same row.
// After reset and after every block, sets or ways register write a clearing
// pass sweeps the directory one row a cycle (MAX_BLOCKS / LANES rows, 1024
// at defaults); in_tready is low during it. Counters survive register writes.
// A pending result waits in the output register; the update beat stalls
// only while that register is still full.
module set_assoc_cache_lru_model_core #(
  parameter int MAX_BLOCKS = sacl_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sacl_pkg::IN_DATA_W-1:0]    in_tdata,   // [30:0] address, [31] zero
  input  logic                              in_tuser,   // kind

  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sacl_pkg::OUT_DATA_W-1:0]   out_tdata,  // [2:0] way_used, [34:3] hit_total,
                                                        // [66:35] access_total,
                                                        // [106:67] fill_bytes,
                                                        // [146:107] writeback_bytes
  output logic                              out_tuser,  // hit

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sacl_pkg::*;

  // directory geometry: a row holds LANES ways, a set never crosses a row
  localparam int BLK_LOG     = flog2(MAX_BLOCKS);
  localparam int WAY_LOG_MAX = min_int(min_int(WAY_LOG_CAP, flog2(MAX_WAYS)), BLK_LOG);
  localparam int LANES       = 1 << WAY_LOG_MAX;
  localparam int LW          = (WAY_LOG_MAX > 0) ? WAY_LOG_MAX : 1;
  localparam int ROW_W       = BLK_LOG - WAY_LOG_MAX;
  localparam int ROWS        = 1 << ROW_W;
  localparam int SH_W        = 5;

  // ---------------- configuration registers ----------------
  logic [BB_W-1:0] bb_r;
  logic [SC_W-1:0] sc_r;
  logic [WL_W-1:0] wl_r;
  logic            cfg_clear;

  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (cfg_index)
      CFG_BLOCK, CFG_SETS, CFG_WAYS: cfg_clear = cfg_valid;
      default:                       cfg_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r <= BB_W'(3);
      sc_r <= SC_W'(7);
      wl_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLOCK: bb_r <= cfg_data[BB_W-1:0];
        CFG_SETS:  sc_r <= cfg_data[SC_W-1:0];
        CFG_WAYS:  wl_r <= cfg_data[WL_W-1:0];
        default:   ;
      endcase
    end
  end

  // ---------------- effective geometry ----------------
  logic [BB_W-1:0]  bl_eff;
  logic [WL_W-1:0]  wl_eff;
  logic [SC_W-1:0]  sl_eff;
  logic [SH_W-1:0]  s_lim;
  logic [LW-1:0]    way_mask;

  always_comb begin
    if (bb_r < BB_W'(BLK_LOG_MIN))      bl_eff = BB_W'(BLK_LOG_MIN);
    else if (bb_r > BB_W'(BLK_LOG_MAX)) bl_eff = BB_W'(BLK_LOG_MAX);
    else                                bl_eff = bb_r;
    wl_eff = ({1'b0, wl_r} > (WL_W + 1)'(WAY_LOG_MAX)) ? WL_W'(WAY_LOG_MAX) : wl_r;
    s_lim  = SH_W'(BLK_LOG) - SH_W'(wl_eff);
    sl_eff = (SH_W'(sc_r) > s_lim) ? s_lim[SC_W-1:0] : sc_r;
  end

  assign way_mask = LW'((4'd1 << wl_eff) - 4'd1);

  // ---------------- address split ----------------
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  set_full;
  logic [ADDR_W-1:0]  base_full;
  logic [BLK_LOG-1:0] base;
  logic [ROW_W-1:0]   row;
  logic [LW-1:0]      off;
  logic [TAG_W-1:0]   tag;

  assign addr      = in_tdata[ADDR_W-1:0];
  assign set_full  = (addr >> bl_eff) & ~({ADDR_W{1'b1}} << sl_eff);
  assign base_full = set_full << wl_eff;
  assign base      = base_full[BLK_LOG-1:0];
  assign row       = base[BLK_LOG-1:WAY_LOG_MAX];
  assign off       = base[LW-1:0] & LW'(LANES - 1);
  assign tag       = TAG_W'(addr >> (SH_W'(bl_eff) + SH_W'(sl_eff)));

  // ---------------- control ----------------
  sacl_state_t      state_r, state_nxt;
  logic [ROW_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             in_fire;
  logic             look_go;
  logic             out_tvalid_r;

  logic             kind_r;
  logic [TAG_W-1:0] tag_r;
  logic [ROW_W-1:0] row_r;
  logic [LW-1:0]    off_r;

  assign in_fire = in_tvalid && in_tready;
  assign look_go = (state_r == ST_LOOK) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    in_tready   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ROW_W'(1);
        if (&clr_cnt_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (look_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
    // a geometry change restarts the sweep
    if (cfg_clear) begin
      state_nxt   = ST_CLEAR;
      clr_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_tuser;
      tag_r  <= tag;
      row_r  <= row;
      off_r  <= off;
    end
  end

  // ---------------- directory ----------------
  tag_ent_t [LANES-1:0]     rd_tag, tag_row_nx, wr_tag, clr_tag;
  logic [LANES-1:0][LW-1:0] rd_lru, lru_row_nx, wr_lru, clr_lru;
  logic                     wr_en;
  logic [ROW_W-1:0]         wr_addr;
  logic                     hit;
  logic [LW-1:0]            way;

  // reset row: all invalid, position p holds way p (masked on read)
  always_comb begin
    clr_tag = '0;
    for (int j = 0; j < LANES; j++) clr_lru[j] = LW'(j);
  end

  assign wr_en   = (state_r == ST_CLEAR) || look_go;
  assign wr_addr = (state_r == ST_CLEAR) ? clr_cnt_r : row_r;
  assign wr_tag  = (state_r == ST_CLEAR) ? clr_tag : tag_row_nx;
  assign wr_lru  = (state_r == ST_CLEAR) ? clr_lru : lru_row_nx;

  sacl_dir_mem #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W),
    .LANES (LANES),
    .LW    (LW)
  ) u_dir (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_tag  (wr_tag),
    .wr_lru  (wr_lru),
    .rd_tag  (rd_tag),
    .rd_lru  (rd_lru)
  );

  sacl_set_upd #(
    .LANES (LANES),
    .LW    (LW)
  ) u_upd (
    .tag_row    (rd_tag),
    .lru_row    (rd_lru),
    .off        (off_r),
    .way_mask   (way_mask),
    .tag        (tag_r),
    .hit        (hit),
    .way        (way),
    .tag_row_nx (tag_row_nx),
    .lru_row_nx (lru_row_nx)
  );

  // ---------------- counters ----------------
  ctr_evt_t evt;
  ctr_val_t cnt_nxt;

  assign evt.fire     = look_go;
  assign evt.hit      = hit;
  assign evt.is_write = kind_r;
  assign evt.blk_log  = bl_eff;

  sacl_counters u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .evt     (evt),
    .cnt_nxt (cnt_nxt)
  );

  // ---------------- output register ----------------
  logic                 out_hit_r;
  logic [WAY_OUT_W-1:0] out_way_r;
  ctr_val_t             out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (look_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_go) begin
      out_hit_r <= hit;
      out_way_r <= WAY_OUT_W'(way);
      out_cnt_r <= cnt_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {5'd0, out_cnt_r.wb, out_cnt_r.fill, out_cnt_r.accesses,
                       out_cnt_r.hits, out_way_r};

  // ---------------- assertions ----------------
  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_clear |=> state_r == ST_LOOK)
    else $error("accepted access did not enter update beat");

  a_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> (state_r == ST_CLEAR) && (clr_cnt_r == '0))
    else $error("register write did not restart clearing pass");

  a_look_loads: assert property (@(posedge clk) disable iff (!rst_n)
    look_go |=> out_tvalid_r && (state_r == ST_IDLE || state_r == ST_CLEAR))
    else $error("update beat did not load output register");

  a_hits_le_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_cnt_r.hits <= out_cnt_r.accesses)
    else $error("hit total above access total");

endmodule

[tb/sv/set_assoc_cache_lru_checker.sv]
`timescale 1ns / 1ps
module set_assoc_cache_lru_checker #(
  parameter int MAX_BLOCKS = sacl_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_WAYS   = sacl_pkg::DEF_MAX_WAYS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [sacl_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [sacl_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending_results
);
  import sacl_pkg::*;

  localparam int SETS_LOG_RESET = 7;

  typedef struct packed {
    logic              hit;
    logic [2:0]        way;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  accesses;
    logic [BYTE_W-1:0] fill;
    logic [BYTE_W-1:0] wb;
  } access_result_t;

  logic [BB_W-1:0]   blk_reg;
  logic [SC_W-1:0]   sets_reg;
  logic [WL_W-1:0]   ways_reg;

  logic              line_vld [MAX_BLOCKS];
  logic [ADDR_W-1:0] line_tag [MAX_BLOCKS];
  logic [2:0]        lru_way  [MAX_BLOCKS];

  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  access_count;
  logic [BYTE_W-1:0] fill_count;
  logic [BYTE_W-1:0] wb_count;

  access_result_t    predicted_q [$];

  // effective geometry after clamping
  function automatic void live_geometry(output int bl, output int sl, output int wl);
    bl = blk_reg;
    if (bl < BLK_LOG_MIN) bl = BLK_LOG_MIN;
    if (bl > BLK_LOG_MAX) bl = BLK_LOG_MAX;
    wl = ways_reg;
    while (wl > 0 && ((1 << wl) > MAX_WAYS || (1 << wl) > MAX_BLOCKS)) wl--;
    sl = sets_reg;
    while (sl > 0 && (1 << (sl + wl)) > MAX_BLOCKS) sl--;
  endfunction

  function automatic void clear_directory();
    int bl, sl, wl;
    live_geometry(bl, sl, wl);
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      line_vld[i] = 1'b0;
      line_tag[i] = '0;
      lru_way[i]  = 3'(i & ((1 << wl) - 1));
    end
  endfunction

  function automatic logic [BYTE_W-1:0] sat_bytes(input logic [BYTE_W-1:0] v, input int bl);
    logic [63:0] sum;
    sum = 64'(v) + (64'd1 << bl);
    return (sum > 64'hFF_FFFF_FFFF) ? '1 : sum[BYTE_W-1:0];
  endfunction

  // one lookup: tag compare, fill on miss, LRU move-to-front, counters
  function automatic access_result_t access_directory(input logic is_write,
                                                      input logic [ADDR_W-1:0] addr);
    int bl, sl, wl, nw, base, set_idx, way, pos;
    logic [ADDR_W-1:0] tag;
    logic found;
    access_result_t r;
    live_geometry(bl, sl, wl);
    nw      = 1 << wl;
    set_idx = (addr >> bl) & ((1 << sl) - 1);
    tag     = addr >> (bl + sl);
    base    = set_idx << wl;
    found   = 1'b0;
    way     = 0;
    pos     = 0;
    for (int i = 0; i < nw; i++) begin
      if (line_vld[base + i] && line_tag[base + i] == tag) begin
        found = 1'b1;
        way   = i;
      end
    end
    if (!found) begin
      way = lru_way[base] & (nw - 1);
      line_vld[base + way] = 1'b1;
      line_tag[base + way] = tag;
    end
    for (int i = 0; i < nw; i++)
      if ((lru_way[base + i] & (nw - 1)) == way) pos = i;
    for (int i = pos; i + 1 < nw; i++) lru_way[base + i] = lru_way[base + i + 1];
    lru_way[base + nw - 1] = 3'(way);

    if (access_count != '1) access_count++;
    if (found) begin
      if (hit_count != '1) hit_count++;
    end else if (is_write) begin
      wb_count = sat_bytes(wb_count, bl);
    end else begin
      fill_count = sat_bytes(fill_count, bl);
    end

    r.hit      = found;
    r.way      = 3'(way);
    r.hits     = hit_count;
    r.accesses = access_count;
    r.fill     = fill_count;
    r.wb       = wb_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                             input logic [BYTE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    access_result_t want;
    access_result_t pred;
    if (!rst_n) begin
      blk_reg      = BB_W'(BLK_LOG_MIN);
      sets_reg     = SC_W'(SETS_LOG_RESET);
      ways_reg     = '0;
      hit_count    = '0;
      access_count = '0;
      fill_count   = '0;
      wb_count     = '0;
      mismatches   = 0;
      predicted_q.delete();
      clear_directory();
    end else begin
      // result beat first, so a beat with nothing outstanding is caught
      if (out_tvalid && out_tready) begin
        if (predicted_q.size() == 0) begin
          $error("result beat with no access outstanding");
          mismatches++;
        end else begin
          want = predicted_q.pop_front();
          check_field("hit", want.hit, out_tuser);
          check_field("way_used", want.way, out_tdata[2:0]);
          check_field("hit_total", want.hits, out_tdata[34:3]);
          check_field("access_total", want.accesses, out_tdata[66:35]);
          check_field("fill_bytes", want.fill, out_tdata[106:67]);
          check_field("writeback_bytes", want.wb, out_tdata[146:107]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCK: begin
            blk_reg = cfg_data[BB_W-1:0];
            clear_directory();
          end
          CFG_SETS: begin
            sets_reg = cfg_data[SC_W-1:0];
            clear_directory();
          end
          CFG_WAYS: begin
            ways_reg = cfg_data[WL_W-1:0];
            clear_directory();
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pred = access_directory(in_tuser, in_tdata[ADDR_W-1:0]);
        predicted_q.insert(predicted_q.size(), pred);
      end
    end
    pending_results <= predicted_q.size();
  end

endmodule

[tb/sv/tb_set_assoc_cache_lru_model_core.sv]
`timescale 1ns / 1ps
module tb_set_assoc_cache_lru_model_core;
  import sacl_pkg::*;

  // access kinds carried in in_tuser
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 150;
  // worst case: ~20 register writes x 1024-row clears plus ~800 slow beats
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_AT         = 250;   // result beat after which the sink goes quiet
  localparam int HOLD_CYCLES     = 300;

  logic                    clk;
  logic                    rst_n      = 1'b0;

  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata   = '0;   // [30:0] address, [31] zero
  logic                    in_tuser   = 1'b0; // kind

  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;         // way_used, hit_total, access_total,
                                              // fill_bytes, writeback_bytes
  logic                    out_tuser;         // hit

  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data   = '0;

  int                      check_errors;
  int                      results_left;

  // source / sink idle enables, flipped in stretches
  bit                      src_gaps = 1'b1;
  bit                      sink_gaps = 1'b1;
  int                      results_taken = 0;

  // working set for the random part: addresses sharing bits [18:0] land in
  // the same set for every geometry (offset + index never exceed 19 bits)
  logic [11:0]             tag_pool [16];
  logic [15:0]             set_pool [2];
  int                      tag_pool_n;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  set_assoc_cache_lru_model_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  set_assoc_cache_lru_checker lru_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (check_errors),
    .pending_results (results_left)
  );

  // One access beat. valid only drops when a gap is actually taken, so
  // back-to-back beats never see a low/high pair in the same step.
  task automatic send_access(input logic kind, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = src_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, addr};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
  endtask

  // Wait for every outstanding result; the checker's count is registered,
  // hence the wait for an edge before looking at it.
  task automatic wait_drained();
    @(posedge clk);
    while (results_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register beats only go out with the pipe empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // raw register data per random pass: {block, sets, ways}; out-of-range
  // values exercise the clamps (block 0/7, sets 15 with 8 ways)
  function automatic logic [11:0] pass_geometry(input int p);
    case (p)
      0:       return {4'hF, 4'd13, 4'h8};   // 64B blocks, 8192 sets, direct mapped
      1:       return {4'h0, 4'hF,  4'hF};   // 8B blocks, sets cut to 1024, 8 ways
      2:       return {4'h4, 4'h2,  4'h2};
      3:       return {4'h8, 4'h0,  4'h1};   // single set, 2 ways
      default: return {4'h5, 4'h9,  4'h3};
    endcase
  endfunction

  task automatic fill_pool();
    tag_pool_n = $urandom_range(2, 16);
    for (int i = 0; i < 16; i++) tag_pool[i] = 12'($urandom_range(0, 4095));
    for (int i = 0; i < 2; i++) set_pool[i] = 16'($urandom_range(0, 65535));
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int roll;
    logic [ADDR_W-1:0] a;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      // conflict-heavy: few tags over two sets, random byte offset
      a = {tag_pool[$urandom_range(0, tag_pool_n - 1)],
           set_pool[$urandom_range(0, 1)],
           3'($urandom_range(0, 7))};
    end else if (roll < 85) begin
      a = ADDR_W'($urandom_range(0, 4095));       // small region, reuse across sets
    end else begin
      a = ADDR_W'($urandom);                      // noise over the whole space
    end
    return a;
  endfunction

  // Sink: per-beat random stall, plus one long hold-off so the core
  // backs up and drops in_tready while the source keeps offering.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = sink_gaps ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      results_taken++;
      if (results_taken % 64 == 0) sink_gaps = ($urandom_range(0, 2) != 0);
      if (results_taken == HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [11:0] geo;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed, reset geometry: 8B blocks, 128 sets, direct mapped ----
    send_access(KIND_READ,  31'h0000_0000);   // cold miss, fill
    send_access(KIND_READ,  31'h0000_0004);   // same block: hit
    send_access(KIND_WRITE, 31'h7FFF_FFFF);   // top address, write miss
    send_access(KIND_WRITE, 31'h7FFF_FFF8);   // hit
    send_access(KIND_READ,  31'h0000_0400);   // same set, new tag: replace
    send_access(KIND_WRITE, 31'h0000_0000);   // write miss also allocates
    send_access(KIND_READ,  31'h0000_0000);   // and now hits

    // ---- directed, one set of 8 ways, 64B blocks: LRU order ----
    write_reg(CFG_BLOCK, 4'hF);
    write_reg(CFG_SETS,  4'h0);
    write_reg(CFG_WAYS,  4'h3);
    for (int k = 0; k < 9; k++)               // ninth tag evicts the oldest way
      send_access((k % 2 == 0) ? KIND_READ : KIND_WRITE, ADDR_W'(k << 6));
    send_access(KIND_READ, 31'h0000_0040);    // touch tag 1 -> most recent
    send_access(KIND_READ, 31'h0000_0000);    // tag 0 gone; victim skips tag 1

    // ---- random passes over several geometries ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      geo = pass_geometry(p);
      write_reg(CFG_BLOCK, geo[11:8]);
      write_reg(CFG_SETS,  geo[7:4]);
      write_reg(CFG_WAYS,  geo[3:0]);
      if (p == 3) write_reg(CFG_UNUSED, 4'hF); // must leave the directory alone
      fill_pool();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) src_gaps = ($urandom_range(0, 2) != 0);
        if (p == 2 && n == 75) begin
          // source pauses until the core has handed back everything
          in_tvalid <= 1'b0;
          wait_drained();
        end
        send_access(($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_READ, pick_address());
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (check_errors == 0 && results_left == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[set_assoc_cache_lru_model_core.f]
rtl/sacl_pkg.sv
rtl/sacl_dir_mem.sv
rtl/sacl_set_upd.sv
rtl/sacl_counters.sv
rtl/set_assoc_cache_lru_model_core.sv
tb/sv/set_assoc_cache_lru_checker.sv
tb/sv/tb_set_assoc_cache_lru_model_core.sv
